FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the depth sorter.
// Include guarded; holds only property macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that expression holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Assert that antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/pdsc_pkg.sv
// Package for the particle depth sorter: item types and register indexes.
// No dependencies.
`default_nettype none
package pdsc_pkg;
    localparam int COORD_W = 24;
    localparam int KEY_W   = 50;
    localparam logic [1:0] REG_CAMERA_X = 2'd0;
    localparam logic [1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [1:0] REG_CAMERA_Z = 2'd2;

    typedef struct packed {
        logic [15:0] size_y;
        logic [15:0] size_x;
        logic [31:0] colour;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } particle_t;

    // Queue entry between the key front and the sort/emit back.
    typedef struct packed {
        logic               live;
        logic               last;
        logic [KEY_W-1:0]   key;
        particle_t          part;
    } job_t;
endpackage
`default_nettype wire

FILE: rtl/core/pdsc_front.sv
// Front: accepts particles, computes the squared camera distance in a
// three stage pipeline. Depends on pdsc_pkg.
`default_nettype none
module pdsc_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  pdsc_pkg::particle_t in_part,
    input  wire                 in_alive,
    input  wire                 in_last,
    input  wire signed [23:0]   cam_x,
    input  wire signed [23:0]   cam_y,
    input  wire signed [23:0]   cam_z,
    output logic                out_valid,
    input  wire                 out_ready,
    output pdsc_pkg::job_t      out_job
);
    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [24:0]     dx_reg, dy_reg, dz_reg;
    logic [49:0]            sx_reg, sy_reg, sz_reg;
    logic signed [49:0]     sq_x, sq_y, sq_z;
    pdsc_pkg::particle_t    p1_reg, p2_reg;
    logic                   l1_reg, l2_reg, a1_reg, a2_reg;
    pdsc_pkg::job_t         j3_reg;
    logic                   adv;

    assign adv       = !v3_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v3_reg;
    assign out_job   = j3_reg;

    // Full 50-bit signed squares of the 25-bit differences.
    assign sq_x = dx_reg * dx_reg;
    assign sq_y = dy_reg * dy_reg;
    assign sq_z = dz_reg * dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= {in_part.x[23], in_part.x} - {cam_x[23], cam_x};
            dy_reg <= {in_part.y[23], in_part.y} - {cam_y[23], cam_y};
            dz_reg <= {in_part.z[23], in_part.z} - {cam_z[23], cam_z};
            p1_reg <= in_part;
            l1_reg <= in_last;
            a1_reg <= in_alive;
            sx_reg <= unsigned'(sq_x);
            sy_reg <= unsigned'(sq_y);
            sz_reg <= unsigned'(sq_z);
            p2_reg <= p1_reg;
            l2_reg <= l1_reg;
            a2_reg <= a1_reg;
            j3_reg.key  <= sx_reg + sy_reg + sz_reg;
            j3_reg.part <= p2_reg;
            j3_reg.last <= l2_reg;
            j3_reg.live <= a2_reg;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/pdsc_fifo.sv
// Short queue between front and back. Depends on pdsc_pkg.
`default_nettype none
module pdsc_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  pdsc_pkg::job_t  in_job,
    output logic            out_valid,
    input  wire             out_ready,
    output pdsc_pkg::job_t  out_job
);
    pdsc_pkg::job_t mem_reg [4];
    logic [2:0] wp_reg, rp_reg;
    logic [2:0] cnt;

    assign cnt       = wp_reg - rp_reg;
    assign in_ready  = cnt != 3'd4;
    assign out_valid = cnt != 3'd0;
    assign out_job   = mem_reg[rp_reg[1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (in_valid && in_ready) wp_reg <= wp_reg + 3'd1;
            if (out_valid && out_ready) rp_reg <= rp_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg[1:0]] <= in_job;
    end
endmodule
`default_nettype wire

FILE: rtl/core/pdsc_back.sv
// Back: insertion sort chain of cells, then emission farthest first.
// Depends on pdsc_pkg.
`default_nettype none
module pdsc_back #(
    parameter int MAX_ITEMS = 64
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  pdsc_pkg::job_t  in_job,
    output logic            m_valid,
    input  wire             m_ready,
    output pdsc_pkg::particle_t m_part,
    output logic            m_last,
    output logic            m_none
);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    typedef enum logic [1:0] {LOAD, EMIT, EMPTY} state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [MAX_ITEMS-1:0]   occ_reg;
    logic [49:0]            key_reg  [MAX_ITEMS];
    pdsc_pkg::particle_t    part_reg [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]   goes_after;
    logic                   take, insert, shift;
    logic [CW-1:0]          count_next;

    assign in_ready = (state_reg == LOAD);
    assign take     = in_valid && in_ready;
    assign insert   = take && in_job.live && (count_reg != CW'(MAX_ITEMS));
    assign m_valid  = (state_reg == EMIT) || (state_reg == EMPTY);
    assign m_part   = (state_reg == EMPTY) ? '0 : part_reg[0];
    assign m_none   = (state_reg == EMPTY);
    assign m_last   = (state_reg == EMPTY) || (count_reg == CW'(1));
    assign shift    = (state_reg == EMIT) && m_ready;
    assign count_next = count_reg + (insert ? CW'(1) : CW'(0));

    // Entry keeps its slot if it is filled and its key is at least the new one.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++)
            goes_after[i] = occ_reg[i] && (key_reg[i] >= in_job.key);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (insert && !goes_after[i]) begin
                if (i == 0 || goes_after[(i == 0) ? 0 : i-1]) begin
                    key_reg[i]  <= in_job.key;
                    part_reg[i] <= in_job.part;
                end else begin
                    key_reg[i]  <= key_reg[(i == 0) ? 0 : i-1];
                    part_reg[i] <= part_reg[(i == 0) ? 0 : i-1];
                end
            end else if (shift && i < MAX_ITEMS-1) begin
                key_reg[i]  <= key_reg[(i < MAX_ITEMS-1) ? i+1 : i];
                part_reg[i] <= part_reg[(i < MAX_ITEMS-1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOAD;
            count_reg <= '0;
            occ_reg   <= '0;
        end else begin
            case (state_reg)
                LOAD: begin
                    if (insert) begin
                        count_reg <= count_next;
                        occ_reg   <= {occ_reg[MAX_ITEMS-2:0], 1'b1};
                    end
                    if (take && in_job.last)
                        state_reg <= (count_next == '0) ? EMPTY : EMIT;
                end
                EMIT: begin
                    if (m_ready) begin
                        count_reg <= count_reg - CW'(1);
                        occ_reg   <= occ_reg >> 1;
                        if (count_reg == CW'(1)) state_reg <= LOAD;
                    end
                end
                EMPTY: begin
                    if (m_ready) state_reg <= LOAD;
                end
                default: state_reg <= LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/particle_depth_sort_compact.sv
// Particle depth sorter: particles in, live ones out sorted farthest first.
// Uses pdsc_pkg, pdsc_front, pdsc_fifo, pdsc_back and assert_macros.svh.
// s_axis: one particle per transaction, tlast marks the final particle of a
// system. The front computes the squared distance to the camera in three
// pipeline stages, one particle per cycle while the queue accepts, into a
// four entry queue. The back is a chain of MAX_ITEMS sort cells; each cell
// compares its key with the new one and holds or shifts, so one particle is
// inserted per cycle while loading. After tlast the back emits the stored
// particles on m_axis, one per cycle while m_axis is ready, farthest first,
// tlast on the final one, and takes no input while emitting. With no live
// particle a single transaction with tuser (none_alive) set and zero data is
// sent. A stall on m_axis holds the current result and backs up through the
// queue to s_axis_tready. Reset empties the queue and the cells and clears
// the camera registers to zero. Camera registers are written on the cfg
// channel (index 0..2 = x, y, z), always ready. A tlast passes the front
// stages, the queue and the back state register before any result is out.
`include "assert_macros.svh"
`default_nettype none
module particle_depth_sort_compact #(
    parameter int MAX_ITEMS = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], colour[103:72],
    // size_x[119:104], size_y[135:120]
    input  wire [135:0]  s_axis_tdata,
    input  wire          s_axis_tuser,   // alive
    input  wire          s_axis_tlast,   // is_last
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48], out_colour[103:72],
    // out_size_x[119:104], out_size_y[135:120]
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tuser,   // none_alive
    output logic         m_axis_tlast,   // last_out
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [1:0]    cfg_index,
    input  wire [23:0]   cfg_data
);
    logic signed [23:0]  cam_x_reg, cam_y_reg, cam_z_reg;
    pdsc_pkg::job_t      f_job, q_job;
    logic                f_valid, f_ready, q_valid, q_ready;
    pdsc_pkg::particle_t m_part;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pdsc_pkg::REG_CAMERA_X: cam_x_reg <= cfg_data;
                pdsc_pkg::REG_CAMERA_Y: cam_y_reg <= cfg_data;
                pdsc_pkg::REG_CAMERA_Z: cam_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pdsc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_part(pdsc_pkg::particle_t'(s_axis_tdata)),
        .in_alive(s_axis_tuser), .in_last(s_axis_tlast),
        .cam_x(cam_x_reg), .cam_y(cam_y_reg), .cam_z(cam_z_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
    );

    pdsc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    pdsc_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_part(m_part), .m_last(m_axis_tlast), .m_none(m_axis_tuser)
    );

    assign m_axis_tdata = m_part;

    `ASSERT_ALWAYS(a_none_is_last, aclk, aresetn, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast)
    `ASSERT_ALWAYS(a_none_zero, aclk, aresetn, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == '0))
    `ASSERT_NEXT(a_no_load_emit, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire
